@@ hw/rtl/pobea_pkg.sv @@
package pobea_pkg;

  // Word widths of the stream fields.
  localparam int DIST_W   = 16;
  localparam int HEIGHT_W = 18;
  localparam int BULGE_W  = 17;
  localparam int VIS_W    = 19;
  localparam int DIFF_W   = 20;
  localparam int ANGLE_W  = 16;

  // Rotation datapath widths and limits.
  localparam int XY_W      = 36;
  localparam int Z_W       = 32;
  localparam int TABLE_LEN = 24;
  localparam int TABLE_IW  = 5;
  localparam int CORDIC_STEPS_DEFAULT = 16;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

  // Bulge scaling: D*D*10 over 4096*127, rounded half up.
  localparam logic [35:0] BULGE_ROUND = 36'd260096;
  // ceil(2^31 / 127); exact floor division by 127 for any 24-bit dividend.
  localparam logic [24:0] RECIP_127   = 25'd16909321;
  localparam int          RECIP_SHIFT = 31;
  // x scaling so that y/x keeps the metre ratio: 125 * 256.
  localparam logic [XY_W-1:0] X_SCALE = 36'd32000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_DIFF,
    ST_LAUNCH,
    ST_ROTATE,
    ST_FINISH
  } state_t;

  // Arctangent of 2^-i in units of 2^-24 degree.
  function automatic logic [29:0] atan_entry(input logic [TABLE_IW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/pobea_cordic.sv @@
module pobea_cordic #(
  parameter int CORDIC_STEPS = pobea_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [pobea_pkg::DIST_W-1:0]          distance,
  input  logic signed [pobea_pkg::DIFF_W-1:0]   dh,
  output logic                                  done,
  output logic signed [pobea_pkg::ANGLE_W-1:0]  angle
);

  localparam int STEPS = (CORDIC_STEPS > pobea_pkg::TABLE_LEN) ?
                         pobea_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam int IW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int XW    = pobea_pkg::XY_W;
  localparam int ZW    = pobea_pkg::Z_W;

  logic                 running;
  logic [IW-1:0]        step;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] atan_val;
  logic                 last_step;

  logic signed [ZW:0]   z_round;
  logic signed [ZW-16:0] z_deg;

  assign xs        = x >>> step;
  assign ys        = y >>> step;
  assign atan_val  = $signed(ZW'(pobea_pkg::atan_entry(pobea_pkg::TABLE_IW'(step))));
  assign last_step = (step == IW'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (last_step) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // One micro-rotation per cycle through the shared shifter and adders.
  always_ff @(posedge clk) begin
    if (start) begin
      x <= $signed(XW'(distance) * pobea_pkg::X_SCALE);
      y <= $signed({{(XW-pobea_pkg::DIFF_W-9){dh[pobea_pkg::DIFF_W-1]}}, dh, 9'd0});
      z <= '0;
    end else if (running) begin
      if (!y[XW-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_val;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_val;
      end
    end
  end

  // Round from 2^-24 degree to 1/256 degree and clamp to a right angle.
  always_comb begin
    z_round = {z[ZW-1], z} + (ZW+1)'(32768);
    z_deg   = z_round[ZW:16];
    if (z_deg > (ZW-15)'(pobea_pkg::ANGLE_LIMIT)) begin
      angle = pobea_pkg::ANGLE_LIMIT;
    end else if (z_deg < -(ZW-15)'(pobea_pkg::ANGLE_LIMIT)) begin
      angle = -pobea_pkg::ANGLE_LIMIT;
    end else begin
      angle = z_deg[pobea_pkg::ANGLE_W-1:0];
    end
  end

endmodule

@@ hw/rtl/path_obstacle_elevation_angle.sv @@
// An accepted word passes through ST_SQUARE, ST_SCALE, ST_DIFF and ST_LAUNCH; with nonzero
// distance the shared CORDIC unit then rotates, one micro-rotation a cycle, before ST_FINISH
// places the result word on the master side. A new word is accepted only once the last
// result has been registered for output; the next word is taken while a result waits.
// Reset (synchronous, rst high) clears the station height, the running extremes and all
// handshake state.
module path_obstacle_elevation_angle #(
  parameter int CORDIC_STEPS = pobea_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // distance_km[15:0], obstacle_height[33:16], zero fill
  input  logic [39:0]  s_tdata,
  // path_start[0]
  input  logic [0:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // earth_bulge[16:0], visible_height[35:17], height_difference[55:36],
  // elevation_angle[71:56], lowest_angle[87:72], highest_angle[103:88]
  output logic [103:0] m_tdata,
  // angle_undefined[0]
  output logic [0:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic [17:0]  cfg_data,
  input  logic         cfg_valid,
  output logic         cfg_ready
);

  localparam int DW = pobea_pkg::DIST_W;
  localparam int HW = pobea_pkg::HEIGHT_W;
  localparam int BW = pobea_pkg::BULGE_W;
  localparam int VW = pobea_pkg::VIS_W;
  localparam int FW = pobea_pkg::DIFF_W;
  localparam int AW = pobea_pkg::ANGLE_W;

  pobea_pkg::state_t state, state_next;

  logic signed [HW-1:0] station_height;

  logic [DW-1:0]        distance;
  logic signed [HW-1:0] height;
  logic                 path_start;
  logic [2*DW-1:0]      sq;
  logic [48:0]          prod;
  logic [BW-1:0]        bulge;
  logic signed [VW-1:0] vis;
  logic signed [FW-1:0] dh;
  logic signed [AW-1:0] ang;
  logic                 undef;

  logic signed [AW-1:0] lowest;
  logic signed [AW-1:0] highest;
  logic                 any_seen;
  logic signed [AW-1:0] lowest_next;
  logic signed [AW-1:0] highest_next;
  logic                 any_seen_next;

  logic [35:0]          sq10;
  logic [23:0]          quot_in;
  logic [17:0]          quot;
  logic [BW-1:0]        bulge_c;
  logic signed [VW-1:0] vis_c;
  logic signed [FW-1:0] dh_c;

  logic                 in_fire;
  logic                 out_free;
  logic                 commit;
  logic                 cordic_start;
  logic                 cordic_done;
  logic signed [AW-1:0] cordic_angle;

  assign s_tready  = (state == pobea_pkg::ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign commit    = (state == pobea_pkg::ST_FINISH) && out_free;
  assign cfg_ready = 1'b1;

  assign cordic_start = (state == pobea_pkg::ST_LAUNCH) && (distance != '0);

  pobea_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cordic_start),
    .distance (distance),
    .dh       (dh),
    .done     (cordic_done),
    .angle    (cordic_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pobea_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pobea_pkg::ST_IDLE:   if (in_fire) state_next = pobea_pkg::ST_SQUARE;
      pobea_pkg::ST_SQUARE: state_next = pobea_pkg::ST_SCALE;
      pobea_pkg::ST_SCALE:  state_next = pobea_pkg::ST_DIFF;
      pobea_pkg::ST_DIFF:   state_next = pobea_pkg::ST_LAUNCH;
      pobea_pkg::ST_LAUNCH: begin
        state_next = (distance == '0) ? pobea_pkg::ST_FINISH : pobea_pkg::ST_ROTATE;
      end
      pobea_pkg::ST_ROTATE: if (cordic_done) state_next = pobea_pkg::ST_FINISH;
      pobea_pkg::ST_FINISH: if (out_free) state_next = pobea_pkg::ST_IDLE;
      default:              state_next = pobea_pkg::ST_IDLE;
    endcase
  end

  // Bulge: round(D*D*10 / (4096*127)); the division by 127 is a reciprocal multiply.
  always_comb begin
    sq10    = {sq, 3'd0} + {3'd0, sq, 1'b0} + pobea_pkg::BULGE_ROUND;
    quot_in = sq10[35:12];
    quot    = prod[48:pobea_pkg::RECIP_SHIFT];
    bulge_c = quot[17] ? {BW{1'b1}} : quot[BW-1:0];
    vis_c   = $signed({height[HW-1], height}) - $signed({2'b00, bulge_c});
    dh_c    = $signed({vis_c[VW-1], vis_c}) -
              $signed({{(FW-HW){station_height[HW-1]}}, station_height});
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      distance   <= s_tdata[DW-1:0];
      height     <= $signed(s_tdata[DW+HW-1:DW]);
      path_start <= s_tuser[0];
    end
    if (state == pobea_pkg::ST_SQUARE) begin
      sq <= distance * distance;
    end
    if (state == pobea_pkg::ST_SCALE) begin
      prod <= 49'(quot_in) * 49'(pobea_pkg::RECIP_127);
    end
    if (state == pobea_pkg::ST_DIFF) begin
      bulge <= bulge_c;
      vis   <= vis_c;
      dh    <= dh_c;
    end
    if (state == pobea_pkg::ST_LAUNCH) begin
      // Vertical sight line at zero distance: straight up, straight down, or no direction at all.
      if (distance != '0) begin
        ang   <= '0;
        undef <= 1'b0;
      end else if (dh > 0) begin
        ang   <= pobea_pkg::ANGLE_LIMIT;
        undef <= 1'b0;
      end else if (dh < 0) begin
        ang   <= -pobea_pkg::ANGLE_LIMIT;
        undef <= 1'b0;
      end else begin
        ang   <= '0;
        undef <= 1'b1;
      end
    end
    if ((state == pobea_pkg::ST_ROTATE) && cordic_done) begin
      ang <= cordic_angle;
    end
  end

  // Running extremes: a path start clears them before this obstacle is counted.
  always_comb begin
    lowest_next   = path_start ? '0 : lowest;
    highest_next  = path_start ? '0 : highest;
    any_seen_next = path_start ? 1'b0 : any_seen;
    if (!undef) begin
      if (!any_seen_next) begin
        lowest_next   = ang;
        highest_next  = ang;
        any_seen_next = 1'b1;
      end else begin
        if (ang < lowest_next) lowest_next = ang;
        if (ang > highest_next) highest_next = ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_height <= '0;
      lowest         <= '0;
      highest        <= '0;
      any_seen       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        station_height <= $signed(cfg_data);
      end
      if (commit) begin
        lowest   <= lowest_next;
        highest  <= highest_next;
        any_seen <= any_seen_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {highest_next, lowest_next, ang, dh, vis, bulge};
      m_tuser <= undef;
    end
  end

endmodule
